// ----- rtl/ulcd_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and charset mapping for the character lcd line writer
// no dependencies
package ulcd_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] NOT_SHOWN  = 8'hCD;
  localparam logic [7:0] LINE_BASE_RST = 8'h80;

  localparam logic [15:0] CODE_TAB = 16'h0009;
  localparam logic [15:0] CODE_LF  = 16'h000A;
  localparam logic [15:0] CODE_FF  = 16'h000C;
  localparam logic [15:0] CODE_CR  = 16'h000D;
  localparam logic [7:0]  BOM_B0   = 8'hEF;
  localparam logic [7:0]  BOM_B1   = 8'hBB;
  localparam logic [15:0] BOM_B2   = 16'h00BF;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BASE = 2'd1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] char_code;
    logic        [7:0]  move_column;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_HOME  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PUT   = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  localparam logic [7:0] CYR_MAIN [64] = '{
    8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
    8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
    8'hac, 8'he2, 8'had, 8'hae, 8'h07, 8'haf, 8'hb0, 8'hb1,
    8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
    8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
    8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
    8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
  };

  // code point to display charset, unmapped shows as NOT_SHOWN
  function automatic logic [7:0] map_code(input logic [15:0] v);
    logic [8:0] page;
    logic [6:0] low;
    logic [7:0] m;
    page = v[15:7];
    low  = v[6:0];
    m    = 8'h00;
    if (page == 9'h000) begin
      if (low >= 7'h20) begin
        case (low)
          7'h5C: m = 8'h04;
          7'h7B: m = 8'h05;
          7'h7C: m = 8'hD1;
          7'h7D: m = 8'h06;
          7'h7E: m = 8'hE9;
          7'h7F: m = 8'hFF;
          default: m = {1'b0, low};
        endcase
      end
    end else if (page == 9'h008) begin
      if (low == 7'h01) m = 8'hA2;
      else if (low == 7'h51) m = 8'hB5;
      else if (low >= 7'h10 && low < 7'h50) m = CYR_MAIN[6'(low - 7'h10)];
    end
    return (m == 8'h00) ? NOT_SHOWN : m;
  endfunction

endpackage

// ----- rtl/utf8_char_lcd_line_writer_unit.sv -----
`timescale 1ns / 1ps
// top level of the utf-8 character lcd line writer
// depends on ulcd_pkg, ulcd_front, ulcd_queue, ulcd_back, ulcd_ram
// a put item gives two bus bytes from the back end: the position command, then the character
// a scroll adds the base command, one byte per shifted column (ram read then emit) and a space
// form feed gives COLUMNS+1 items at one per cycle while out_stall is low; moves, homes and pending bytes none
// the back end takes a new op only from idle, once the last put, scroll or clear is done
// reset: synchronous, clears cursor, lead bytes, queue and line-valid bits (line reads as spaces)
module utf8_char_lcd_line_writer_unit #(
  parameter int COLUMNS = ulcd_pkg::COLUMNS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ulcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               in_valid,
  input  ulcd_pkg::in_item_t                 in_item,
  output logic                               in_stall,
  output logic                               out_valid,
  output ulcd_pkg::out_item_t                out_item,
  input  logic                               out_stall
);
  logic          raw_mode;
  logic [7:0]    line_base;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  ulcd_pkg::op_t push_op;
  ulcd_pkg::op_t pop_op;

  // config registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode  <= 1'b0;
      line_base <= ulcd_pkg::LINE_BASE_RST;
    end else if (cfg_we) begin
      if (cfg_index == ulcd_pkg::CFG_RAW_MODE) raw_mode <= cfg_data[0];
      else if (cfg_index == ulcd_pkg::CFG_LINE_BASE) line_base <= cfg_data;
    end
  end

  // front: utf-8 decode and charset mapping into display ops, or raw byte ops in raw mode
  ulcd_front #(.COLUMNS(COLUMNS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .raw_mode (raw_mode),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  // short queue decoupling front and back
  ulcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (push_op),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_op    (pop_op),
    .pop       (q_pop)
  );

  // back: cursor, line store, scroll and clear, registered bus output
  ulcd_back #(.COLUMNS(COLUMNS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .line_base (line_base),
    .q_valid   (q_valid),
    .q_op      (pop_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );
endmodule

// ----- rtl/ulcd_ram.sv -----
`timescale 1ns / 1ps
// generic single write, single registered read memory
// no dependencies
module ulcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/ulcd_front.sv -----
`timescale 1ns / 1ps
// front end: accepts items, decodes utf-8 and maps to display ops
// depends on ulcd_pkg
module ulcd_front #(
  parameter int COLUMNS = ulcd_pkg::COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               raw_mode,
  input  logic               in_valid,
  input  ulcd_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output ulcd_pkg::op_t      q_op
);
  logic [7:0]  first_lead, first_lead_next;
  logic [7:0]  second_lead, second_lead_next;
  logic [15:0] c;
  logic [15:0] cp;
  logic        accept;
  logic        emit;
  logic        is_put;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emit;

  always_comb begin
    first_lead_next  = first_lead;
    second_lead_next = second_lead;
    emit   = 1'b0;
    is_put = 1'b0;
    cp     = 16'h0000;
    q_op.kind = ulcd_pkg::OP_PUT;
    q_op.data = 8'h00;
    c = (in_item.char_code == ulcd_pkg::CODE_TAB) ? 16'h0020 : in_item.char_code;
    if (in_item.req_type) begin
      q_op.kind = ulcd_pkg::OP_MOVE;
      q_op.data = in_item.move_column;
      emit = (in_item.move_column < 8'(COLUMNS));
    end else if (in_item.char_code == ulcd_pkg::CODE_LF) begin
      emit = 1'b0;
    end else if (in_item.char_code == ulcd_pkg::CODE_CR) begin
      q_op.kind = ulcd_pkg::OP_HOME;
      emit = 1'b1;
    end else if (in_item.char_code == ulcd_pkg::CODE_FF) begin
      q_op.kind = ulcd_pkg::OP_CLEAR;
      emit = 1'b1;
      first_lead_next  = 8'h00;
      second_lead_next = 8'h00;
    end else if (raw_mode) begin
      emit = 1'b1;
      q_op.data = (c < 16'd256) ? c[7:0] : ulcd_pkg::NOT_SHOWN;
    end else if (!c[7]) begin
      first_lead_next  = 8'h00;
      second_lead_next = 8'h00;
      cp = c;
      is_put = 1'b1;
    end else if (first_lead == 8'h00) begin
      first_lead_next = c[7:0];
    end else if (second_lead == 8'h00) begin
      if (first_lead[5]) begin
        second_lead_next = c[7:0];
      end else begin
        cp = {5'b0, first_lead[4:0], c[5:0]};
        first_lead_next = 8'h00;
        is_put = 1'b1;
      end
    end else begin
      first_lead_next  = 8'h00;
      second_lead_next = 8'h00;
      // byte-order mark is swallowed
      if (!(first_lead == ulcd_pkg::BOM_B0 && second_lead == ulcd_pkg::BOM_B1 &&
            c == ulcd_pkg::BOM_B2)) begin
        cp = {first_lead[3:0], second_lead[5:0], c[5:0]};
        is_put = 1'b1;
      end
    end
    if (is_put) begin
      emit = 1'b1;
      q_op.data = ulcd_pkg::map_code(cp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_lead  <= 8'h00;
      second_lead <= 8'h00;
    end else if (accept) begin
      first_lead  <= first_lead_next;
      second_lead <= second_lead_next;
    end
  end
endmodule

// ----- rtl/ulcd_queue.sv -----
`timescale 1ns / 1ps
// two-entry op queue between front and back
// depends on ulcd_pkg
module ulcd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ulcd_pkg::op_t push_op,
  output logic          full,
  output logic          pop_valid,
  output ulcd_pkg::op_t pop_op,
  input  logic          pop
);
  ulcd_pkg::op_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_op    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
endmodule

// ----- rtl/ulcd_back.sv -----
`timescale 1ns / 1ps
// back end: cursor, line store, scroll and clear sequencing, bus byte output
// depends on ulcd_pkg and ulcd_ram
module ulcd_back #(
  parameter int COLUMNS = ulcd_pkg::COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          line_base,
  input  logic                q_valid,
  input  ulcd_pkg::op_t       q_op,
  output logic                q_pop,
  output logic                out_valid,
  output ulcd_pkg::out_item_t out_item,
  input  logic                out_stall
);
  localparam int CW = $clog2(COLUMNS + 1);
  localparam int AW = $clog2(COLUMNS);
  localparam logic [CW-1:0] COLS_C = CW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A = AW'(COLUMNS - 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CLR_CMD = 8'b0000_0010,
    S_CLR_SP  = 8'b0000_0100,
    S_SC_CMD  = 8'b0000_1000,
    S_SC_RD   = 8'b0001_0000,
    S_SC_DATA = 8'b0010_0000,
    S_SC_SP   = 8'b0100_0000,
    S_PUT     = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [CW-1:0]      cursor;
  logic [AW-1:0]      idx;
  logic [7:0]         ch;
  logic               put_data;
  logic [COLUMNS-1:0] line_vld;
  logic               adv;
  logic               fire;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         rd_byte;

  assign adv     = !out_valid || !out_stall;
  // every state but idle and the ram read wait emits an item when it advances
  assign fire    = !(state inside {S_IDLE, S_SC_RD});
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign rd_byte = line_vld[idx] ? ram_rdata : ulcd_pkg::SPACE_CHAR;
  assign ram_we  = adv && ((state == S_SC_DATA) || (state == S_PUT && put_data));
  assign ram_waddr = (state == S_SC_DATA) ? AW'(idx - AW'(1)) : cursor[AW-1:0];

  ulcd_ram #(.WIDTH(8), .DEPTH(COLUMNS)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ((state == S_SC_DATA) ? rd_byte : ch),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      idx       <= '0;
      put_data  <= 1'b0;
      line_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= fire;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_op.kind)
              ulcd_pkg::OP_MOVE: cursor <= CW'(q_op.data);
              ulcd_pkg::OP_HOME: cursor <= '0;
              ulcd_pkg::OP_CLEAR: begin
                line_vld <= '0;
                state    <= S_CLR_CMD;
              end
              ulcd_pkg::OP_PUT: begin
                ch       <= q_op.data;
                put_data <= 1'b0;
                state    <= (cursor >= COLS_C) ? S_SC_CMD : S_PUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLR_CMD: if (adv) begin
          out_item  <= '{is_data: 1'b0, bus_byte: line_base, last: 1'b0};
          idx       <= '0;
          state     <= S_CLR_SP;
        end
        S_CLR_SP: if (adv) begin
          out_item  <= '{is_data: 1'b1, bus_byte: ulcd_pkg::SPACE_CHAR,
                         last: (idx == LAST_A)};
          idx       <= AW'(idx + AW'(1));
          if (idx == LAST_A) begin
            cursor <= '0;
            state  <= S_IDLE;
          end
        end
        S_SC_CMD: if (adv) begin
          out_item  <= '{is_data: 1'b0, bus_byte: line_base, last: 1'b0};
          cursor    <= COLS_C;
          idx       <= AW'(1);
          state     <= S_SC_RD;
        end
        // ram read issued this cycle, data ready next
        S_SC_RD: state <= S_SC_DATA;
        S_SC_DATA: if (adv) begin
          out_item  <= '{is_data: 1'b1, bus_byte: rd_byte, last: 1'b0};
          line_vld[AW'(idx - AW'(1))] <= 1'b1;
          if (idx == LAST_A) begin
            state <= S_SC_SP;
          end else begin
            idx   <= AW'(idx + AW'(1));
            state <= S_SC_RD;
          end
        end
        S_SC_SP: if (adv) begin
          out_item  <= '{is_data: 1'b1, bus_byte: ulcd_pkg::SPACE_CHAR, last: 1'b0};
          cursor    <= CW'(cursor - CW'(1));
          state     <= S_PUT;
        end
        S_PUT: if (adv) begin
          if (!put_data) begin
            out_item <= '{is_data: 1'b0, bus_byte: line_base | 8'(cursor), last: 1'b0};
            put_data <= 1'b1;
          end else begin
            out_item <= '{is_data: 1'b1, bus_byte: ch, last: 1'b1};
            line_vld[cursor[AW-1:0]] <= 1'b1;
            cursor   <= CW'(cursor + CW'(1));
            put_data <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= COLS_C) else $error("cursor beyond line width");
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last) |-> out_item.is_data)
    else $error("final item is not a data byte");
  a_put_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (cursor < COLS_C)) else $error("put outside the line");
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// testbench for the utf-8 character lcd line writer: directed table then random items
// depends on ulcd_pkg and utf8_char_lcd_line_writer_unit
module testbench;

  localparam int COLS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ulcd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ulcd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;
  logic                           in_valid;
  ulcd_pkg::in_item_t             in_item;
  logic                           in_stall;
  logic                           out_valid;
  ulcd_pkg::out_item_t            out_item;
  logic                           out_stall;

  utf8_char_lcd_line_writer_unit #(.COLUMNS(COLS)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
    .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
  );

  // predictor state
  logic       mdl_raw;
  logic [7:0] mdl_base;
  logic [7:0] mdl_line [COLS];
  logic [7:0] mdl_col;
  logic [7:0] mdl_lead0;
  logic [7:0] mdl_lead1;

  ulcd_pkg::out_item_t bus_expected [$];
  int        errors;
  int        cycles;
  int        stall_left;

  localparam logic [7:0] CYR_TAB [64] = '{
    8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
    8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
    8'hac, 8'he2, 8'had, 8'hae, 8'h07, 8'haf, 8'hb0, 8'hb1,
    8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
    8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
    8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
    8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
  };

  function automatic logic [7:0] glyph_of(logic [15:0] v);
    logic [6:0] lo;
    logic [7:0] g;
    lo = v[6:0];
    g = 8'h00;
    if (v[15:7] == 9'h000) begin
      if (lo >= 7'h20) begin
        case (lo)
          7'h5C: g = 8'h04;
          7'h7B: g = 8'h05;
          7'h7C: g = 8'hD1;
          7'h7D: g = 8'h06;
          7'h7E: g = 8'hE9;
          7'h7F: g = 8'hFF;
          default: g = {1'b0, lo};
        endcase
      end
    end else if (v[15:7] == 9'h008) begin
      if (lo == 7'h01) g = 8'hA2;
      else if (lo == 7'h51) g = 8'hB5;
      else if (lo >= 7'h10 && lo < 7'h50) g = CYR_TAB[6'(lo - 7'h10)];
    end
    return (g == 8'h00) ? ulcd_pkg::NOT_SHOWN : g;
  endfunction

  task automatic push_bus(logic d, logic [7:0] b);
    ulcd_pkg::out_item_t o;
    o.is_data = d;
    o.bus_byte = b;
    o.last = 1'b0;
    bus_expected.push_back(o);
  endtask

  task automatic mark_last();
    bus_expected[bus_expected.size()-1].last = 1'b1;
  endtask

  task automatic mdl_reset();
    mdl_raw = 1'b0;
    mdl_base = ulcd_pkg::LINE_BASE_RST;
    foreach (mdl_line[k]) mdl_line[k] = ulcd_pkg::SPACE_CHAR;
    mdl_col = 8'd0;
    mdl_lead0 = 8'd0;
    mdl_lead1 = 8'd0;
  endtask

  // works out the bus bytes one item causes
  task automatic predict_bus(ulcd_pkg::in_item_t it);
    logic [15:0] c;
    logic [15:0] cp;
    logic [7:0]  ch;
    c = it.char_code;
    if (it.req_type) begin
      if (it.move_column < COLS) mdl_col = it.move_column;
      return;
    end
    if (c == ulcd_pkg::CODE_LF) return;
    if (c == ulcd_pkg::CODE_CR) begin
      mdl_col = 8'd0;
      return;
    end
    if (c == ulcd_pkg::CODE_FF) begin
      push_bus(1'b0, mdl_base);
      for (int k = 0; k < COLS; k++) begin
        push_bus(1'b1, ulcd_pkg::SPACE_CHAR);
        mdl_line[k] = ulcd_pkg::SPACE_CHAR;
      end
      mdl_col = 8'd0;
      mdl_lead0 = 8'd0;
      mdl_lead1 = 8'd0;
      mark_last();
      return;
    end
    if (c == ulcd_pkg::CODE_TAB) c = 16'h0020;
    if (!mdl_raw) begin
      if (!c[7]) begin
        mdl_lead0 = 8'd0;
        mdl_lead1 = 8'd0;
        cp = c;
      end else if (mdl_lead0 == 8'd0) begin
        mdl_lead0 = c[7:0];
        return;
      end else if (mdl_lead1 == 8'd0) begin
        if (mdl_lead0[5]) begin
          mdl_lead1 = c[7:0];
          return;
        end
        cp = {5'd0, mdl_lead0[4:0], c[5:0]};
        mdl_lead0 = 8'd0;
      end else begin
        if (mdl_lead0 == ulcd_pkg::BOM_B0 && mdl_lead1 == ulcd_pkg::BOM_B1 &&
            c == ulcd_pkg::BOM_B2) begin
          mdl_lead0 = 8'd0;
          mdl_lead1 = 8'd0;
          return;
        end
        cp = {mdl_lead0[3:0], mdl_lead1[5:0], c[5:0]};
        mdl_lead0 = 8'd0;
        mdl_lead1 = 8'd0;
      end
      ch = glyph_of(cp);
    end else begin
      ch = (c < 16'd256) ? c[7:0] : ulcd_pkg::NOT_SHOWN;
    end
    if (mdl_col >= COLS) begin
      mdl_col = COLS;
      push_bus(1'b0, mdl_base);
      for (int k = 1; k < COLS; k++) begin
        push_bus(1'b1, mdl_line[k]);
        mdl_line[k-1] = mdl_line[k];
      end
      push_bus(1'b1, ulcd_pkg::SPACE_CHAR);
      mdl_col = mdl_col - 8'd1;
    end
    push_bus(1'b0, mdl_base | mdl_col);
    push_bus(1'b1, ch);
    if (mdl_col < COLS) mdl_line[mdl_col] = ch;
    mdl_col = mdl_col + 8'd1;
    mark_last();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // output side: random stall, mostly short and a few long, check accepted bus items
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bus_expected.size() == 0) begin
          report_mismatch("unexpected item", out_item, 0);
        end else begin
          ulcd_pkg::out_item_t w;
          w = bus_expected.pop_front();
          if (out_item.is_data !== w.is_data)
            report_mismatch("is_data", out_item.is_data, w.is_data);
          if (out_item.bus_byte !== w.bus_byte)
            report_mismatch("bus_byte", out_item.bus_byte, w.bus_byte);
          if (out_item.last !== w.last) report_mismatch("last", out_item.last, w.last);
        end
      end
      if (cycles % 2000 < 300) begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  task automatic send_item(ulcd_pkg::in_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (cycles % 3000 < 400) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    predict_bus(it);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [ulcd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    // drain and let the block settle before a register write
    in_valid <= 1'b0;
    while (bus_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ulcd_pkg::CFG_RAW_MODE) mdl_raw = val[0];
    else if (idx == ulcd_pkg::CFG_LINE_BASE) mdl_base = val;
  endtask

  function automatic ulcd_pkg::in_item_t put_code(logic [15:0] c);
    ulcd_pkg::in_item_t it;
    it.req_type = 1'b0;
    it.char_code = c;
    it.move_column = 8'($urandom);
    return it;
  endfunction

  function automatic ulcd_pkg::in_item_t move_to(logic [7:0] m);
    ulcd_pkg::in_item_t it;
    it.req_type = 1'b1;
    it.char_code = 16'($urandom);
    it.move_column = m;
    return it;
  endfunction

  // directed rows: move flag, code and target column
  typedef struct {
    logic        mv;
    logic [15:0] code;
    logic [7:0]  col;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{1'b0, 16'h0041, 8'd0},  '{1'b0, 16'h0009, 8'd0},  '{1'b0, 16'h000A, 8'd0},
    '{1'b0, 16'h000D, 8'd0},  '{1'b0, 16'h7FFF, 8'd0},  '{1'b0, 16'h8000, 8'd0},
    '{1'b0, 16'h00D0, 8'd0},  '{1'b0, 16'h0091, 8'd0},  '{1'b0, 16'h00EF, 8'd0},
    '{1'b0, 16'h00BB, 8'd0},  '{1'b0, 16'h00BF, 8'd0},  '{1'b0, 16'h00E2, 8'd0},
    '{1'b0, 16'h0082, 8'd0},  '{1'b0, 16'h00AC, 8'd0},  '{1'b0, 16'h00D1, 8'd0},
    '{1'b0, 16'h0030, 8'd0},  '{1'b1, 16'h0000, 8'd15}, '{1'b0, 16'h005C, 8'd0},
    '{1'b0, 16'h007E, 8'd0},  '{1'b0, 16'h0000, 8'd0},  '{1'b1, 16'hFFFF, 8'd255},
    '{1'b1, 16'h0000, 8'd16}, '{1'b0, 16'h000C, 8'd0},  '{1'b0, 16'hFFFF, 8'd0}
  };

  initial begin
    ulcd_pkg::in_item_t it;
    int r;
    errors = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    mdl_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first put after reset: command base then 'A'
    in_valid <= 1'b1;
    in_item <= put_code(16'h0041);
    push_bus(1'b0, 8'h80);
    push_bus(1'b1, 8'h41);
    mark_last();
    mdl_line[0] = 8'h41;
    mdl_col = 8'd1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].mv) send_item(move_to(dir_rows[k].col));
      else send_item(put_code(dir_rows[k].code));
    end
    // fill past the line end to force scrolls
    for (int k = 0; k < 20; k++) send_item(put_code(16'(16'h0061 + k)));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(ulcd_pkg::CFG_RAW_MODE, 8'd1);
        1: write_reg(ulcd_pkg::CFG_LINE_BASE, 8'hC0);
        2: write_reg(ulcd_pkg::CFG_RAW_MODE, 8'd0);
        3: write_reg(ulcd_pkg::CFG_LINE_BASE, 8'hFF);
        4: write_reg(ulcd_pkg::CFG_LINE_BASE, 8'h00);
        default: begin
          write_reg(CFG_UNUSED, 8'hFF);
          write_reg(ulcd_pkg::CFG_LINE_BASE, 8'h80);
        end
      endcase
      for (int k = 0; k < 18; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) it = move_to(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 17)));
        else if (r < 14) it = put_code(16'h000C);
        else if (r < 18) it = put_code(($urandom_range(0, 1)) ? 16'h000D : 16'h000A);
        else if (r < 20) it = put_code(16'h0009);
        else if (r < 32) it = put_code(16'($urandom));
        else if (r < 55) it = put_code(16'($urandom_range(16'h20, 16'h7F)));
        else if (r < 80) begin
          // two-byte cyrillic, with random upper bits on the bytes
          send_item(put_code({8'($urandom), 3'b110, 5'($urandom_range(16, 17))}));
          it = put_code({8'($urandom), 2'b10, 6'($urandom)});
        end else if (r < 92) begin
          if ($urandom_range(0, 2) == 0) begin
            send_item(put_code(16'h00EF));
            send_item(put_code(16'h00BB));
            it = put_code(16'h00BF);
          end else begin
            send_item(put_code({8'h00, 4'b1110, 4'($urandom)}));
            send_item(put_code({8'h00, 2'b10, 6'($urandom)}));
            it = put_code({8'h00, 2'b10, 6'($urandom)});
          end
        end else it = put_code({8'h00, 1'b1, 7'($urandom)});
        send_item(it);
      end
    end

    in_valid <= 1'b0;
    while (bus_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
